// ===== rtl/mlrc_pkg.sv =====
// Shared types and constants for the motor link response classifier.
package mlrc_pkg;

   // Number of leading packet bytes that are kept for decoding.
   localparam int HDR_DEPTH = 7;

   // Marker bytes of the link protocol.
   localparam logic [7:0] ACK_MARK  = 8'h80;
   localparam logic [7:0] NAK_MARK  = 8'hFF;
   localparam logic [7:0] POLL_LEN  = 8'h03;
   localparam logic [7:0] POLL_CMD  = 8'h00;
   localparam logic [7:0] NAK_SHORT = 8'h03;
   localparam logic [7:0] NAK_MIN   = 8'h01;
   localparam logic [7:0] NAK_MAX   = 8'h08;

   // Packet counts with a special meaning.
   localparam logic [8:0] ACK_COUNT  = 9'd3;
   localparam logic [8:0] NAK_COUNT  = 9'd7;
   localparam logic [9:0] DATA_EXTRA = 10'd3;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SENT_ADDRESS = 2'd0,
      CSR_SENT_LENGTH  = 2'd1,
      CSR_SENT_COMMAND = 2'd2
   } csr_index_type;

   // Request bytes of the transfer that was just sent.
   typedef struct packed {
      logic [7:0] sent_address;
      logic [7:0] sent_length;
      logic [7:0] sent_command;
   } cfg_type;

   // One received byte.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_byte;
   } req_type;

   // One classified packet.
   typedef struct packed {
      logic        packet_good;
      logic        is_ack;
      logic [3:0]  nak_code;
      logic        is_data;
      logic [7:0]  data_length;
      logic [31:0] data_word;
      logic [15:0] poll_status;
      logic [8:0]  byte_count;
   } rsp_type;

   // Running packet totals handed to the classifier.
   typedef struct packed {
      logic [7:0] byte_sum;
      logic [8:0] byte_count;
      logic       count_full;
   } pkt_stat_type;

endpackage

// ===== rtl/mlrc_classify.sv =====
// Combinational decode of a completed packet into one result item.
module mlrc_classify
   import mlrc_pkg::*;
(
   input  cfg_type                            cfg,
   input  pkt_stat_type                       stat,
   input  logic [HDR_DEPTH-1:0][7:0]          hdr,
   output rsp_type                            result
);

   logic        good;
   logic        ack;
   logic [3:0]  nak;
   logic        dat;
   logic [31:0] dword;
   logic [15:0] poll;
   logic        nak_range;

   // Packet integrity: count, checksum and address echo.
   assign good = (stat.byte_count != 9'd0) && !stat.count_full &&
                 (stat.byte_sum == 8'd0) && (hdr[0] == cfg.sent_address);

   // Acknowledge is a three-byte packet with the ack marker.
   assign ack = (stat.byte_count == ACK_COUNT) && (hdr[1] == ACK_MARK);

   // NAK recognition; a seven-byte NAK must carry the short-form code.
   assign nak_range = (hdr[3] >= NAK_MIN) && (hdr[3] <= NAK_MAX);
   always_comb begin
      nak = 4'd0;
      if (!((stat.byte_count == NAK_COUNT) && (hdr[3] != NAK_SHORT)) &&
          (hdr[2] == NAK_MARK) && nak_range && (cfg.sent_length != 8'd0) &&
          (hdr[4] == cfg.sent_command)) begin
         nak = hdr[3][3:0];
      end
   end

   // Data packet: count matches stated length plus header, command echoes.
   assign dat = ({1'b0, stat.byte_count} == ({2'b00, hdr[1]} + DATA_EXTRA)) &&
                (hdr[2] == cfg.sent_command);

   // Data word, big-endian, with bytes past the stated length masked.
   always_comb begin
      dword = 32'd0;
      for (int i = 0; i < 4; i++) begin
         if (8'(i) < hdr[1]) begin
            dword[31-8*i -: 8] = hdr[3+i];
         end
      end
   end

   // Poll response status word.
   assign poll = ((hdr[1] == POLL_LEN) && (hdr[2] == POLL_CMD)) ?
                 {hdr[3], hdr[4]} : 16'd0;

   // Everything but the count is suppressed on a bad packet.
   always_comb begin
      result.packet_good = good;
      result.is_ack      = good && ack;
      result.nak_code    = good ? nak : 4'd0;
      result.is_data     = good && dat;
      result.data_length = (good && dat) ? hdr[1] : 8'd0;
      result.data_word   = (good && dat) ? dword : 32'd0;
      result.poll_status = good ? poll : 16'd0;
      result.byte_count  = stat.byte_count;
   end

endmodule

// ===== rtl/motor_link_response_classifier_core.sv =====
// Top level of the motor link response classifier.
//
//   Channel  Direction  Payload                 Handshake
//   req      in         req_type (one byte)     req_valid / req_ready
//   rsp      out        rsp_type (one packet)   rsp_valid / rsp_ready
//   csr      in         index + 8-bit data      csr_valid / csr_ready
//
// One byte is accepted per cycle while req_ready is high. The packet totals
// update at the accept edge, and on the last byte the decoded result is loaded
// into the output register at that same edge unless it is stalled, so rsp_valid
// is high in the next cycle. A second output register absorbs one result while the
// first is stalled; req_ready drops only while both are full.
// Synchronous reset clears the totals, the header bytes, the registers and the
// valid flags of both output stages. The csr port is always ready.
module motor_link_response_classifier_core
   import mlrc_pkg::*;
#(
   parameter int MAX_PACKET = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_wdata
);

   localparam int CW = $clog2(MAX_PACKET + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PACKET);

   cfg_type                    cfg_ff, cfg_in;
   logic [7:0]                 sum_ff, sum_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [HDR_DEPTH-1:0][7:0]  hdr_ff, hdr_in, hdr_now;
   logic [7:0]                 sum_now;
   logic [CW-1:0]              cnt_now;
   logic                       req_accept;
   logic                       new_result;
   pkt_stat_type               stat;
   rsp_type                    result;
   rsp_type                    out_ff, out_in, skid_ff, skid_in;
   logic                       out_valid_ff, out_valid_in;
   logic                       skid_valid_ff, skid_valid_in;

   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign new_result = req_accept && req_data.last_byte;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;

   // Configuration writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SENT_ADDRESS: cfg_in.sent_address = csr_wdata;
            CSR_SENT_LENGTH:  cfg_in.sent_length  = csr_wdata;
            CSR_SENT_COMMAND: cfg_in.sent_command = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Packet totals including the byte being accepted.
   always_comb begin
      sum_now = sum_ff + req_data.rx_byte;
      cnt_now = (cnt_ff < MAX_CNT) ? CW'(cnt_ff + 1'b1) : cnt_ff;
      for (int i = 0; i < HDR_DEPTH; i++) begin
         hdr_now[i] = (cnt_ff == CW'(i)) ? req_data.rx_byte : hdr_ff[i];
      end
   end

   // Totals clear after the last byte of a packet.
   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      hdr_in = hdr_ff;
      if (req_accept) begin
         if (req_data.last_byte) begin
            sum_in = 8'd0;
            cnt_in = '0;
            hdr_in = '0;
         end else begin
            sum_in = sum_now;
            cnt_in = cnt_now;
            hdr_in = hdr_now;
         end
      end
   end

   // Statistics of the packet as it stands with the current byte.
   always_comb begin
      stat.byte_sum   = sum_now;
      stat.byte_count = 9'(cnt_now);
      stat.count_full = (cnt_now == MAX_CNT);
   end

   mlrc_classify u_classify (
      .cfg    (cfg_ff),
      .stat   (stat),
      .hdr    (hdr_now),
      .result (result)
   );

   // Output register with one skid entry behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff) begin
         out_in       = result;
         out_valid_in = new_result;
      end else if (rsp_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = new_result;
         end
      end else if (new_result) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   // Control and packet state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '0;
         sum_ff        <= 8'd0;
         cnt_ff        <= '0;
         hdr_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         hdr_ff        <= hdr_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== tb/sv/tb_motor_link_response_classifier_core.sv =====
// Self-checking testbench for the motor link response classifier core.
import mlrc_pkg::*;

// Predicts the verdict of each response packet and checks the block's results.
class packet_verdict_board;
   cfg_type    cfg;
   logic [7:0] run_sum;
   logic [8:0] run_count;
   logic [7:0] header [HDR_DEPTH];
   rsp_type    expected_verdicts [$];
   int         mismatch_count;
   int         max_packet;

   function new(int max_packet_size);
      max_packet = max_packet_size;
      mismatch_count = 0;
      cfg = '0;
      clear_packet();
   endfunction

   // All running totals start over at each packet boundary.
   function void clear_packet();
      run_sum = 8'h00;
      run_count = 9'd0;
      foreach (header[i]) header[i] = 8'h00;
   endfunction

   // Writes to the unused index leave the settings alone.
   function void write_reg(logic [1:0] index, logic [7:0] value);
      case (index)
         CSR_SENT_ADDRESS: cfg.sent_address = value;
         CSR_SENT_LENGTH:  cfg.sent_length = value;
         CSR_SENT_COMMAND: cfg.sent_command = value;
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_verdicts.size();
   endfunction

   // Account for one accepted byte; the last byte of a packet yields a verdict.
   function void note_byte(req_type item);
      rsp_type    verdict;
      int         count;
      logic       good;
      logic [7:0] data_byte;
      if (run_count < HDR_DEPTH) header[run_count] = item.rx_byte;
      run_sum = run_sum + item.rx_byte;
      if (run_count < max_packet) run_count = run_count + 9'd1;
      if (!item.last_byte) return;

      count = run_count;
      verdict = '0;
      verdict.byte_count = run_count;
      good = count != 0 && count < max_packet && run_sum == 8'h00 &&
             header[0] == cfg.sent_address;
      // Every classification flag stays clear unless the packet is good.
      if (good) begin
         verdict.packet_good = 1'b1;
         verdict.is_ack = run_count == ACK_COUNT && header[1] == ACK_MARK;
         // A seven-byte NAK must carry the short-form code.
         if (!(run_count == NAK_COUNT && header[3] != NAK_SHORT) &&
             header[2] == NAK_MARK && header[3] >= NAK_MIN && header[3] <= NAK_MAX &&
             cfg.sent_length != 8'h00 && header[4] == cfg.sent_command) begin
            verdict.nak_code = header[3][3:0];
         end
         if (count == int'(header[1]) + int'(DATA_EXTRA) &&
             header[2] == cfg.sent_command) begin
            verdict.is_data = 1'b1;
            verdict.data_length = header[1];
            // Data bytes past the stated length read as zero.
            for (int i = 0; i < 4; i++) begin
               data_byte = (i < int'(header[1])) ? header[3 + i] : 8'h00;
               verdict.data_word = {verdict.data_word[23:0], data_byte};
            end
         end
         if (header[1] == POLL_LEN && header[2] == POLL_CMD) begin
            verdict.poll_status = {header[3], header[4]};
         end
      end
      expected_verdicts.push_back(verdict);
      clear_packet();
   endfunction

   task report_mismatch(string text);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, text);
   endtask

   task compare_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
      end
   endtask

   // Compare one result with the oldest outstanding verdict.
   task check_verdict(rsp_type got);
      rsp_type want;
      if (expected_verdicts.size() == 0) begin
         report_mismatch($sformatf("result with no packet pending, byte_count %0d",
                                   got.byte_count));
         return;
      end
      want = expected_verdicts.pop_front();
      compare_field("packet_good", got.packet_good, want.packet_good);
      compare_field("is_ack", got.is_ack, want.is_ack);
      compare_field("nak_code", got.nak_code, want.nak_code);
      compare_field("is_data", got.is_data, want.is_data);
      compare_field("data_length", got.data_length, want.data_length);
      compare_field("data_word", got.data_word, want.data_word);
      compare_field("poll_status", got.poll_status, want.poll_status);
      compare_field("byte_count", got.byte_count, want.byte_count);
   endtask
endclass

module tb_motor_link_response_classifier_core;

   localparam int         MAX_PACKET   = 256;
   localparam int         RANDOM_ITEMS = 1050;
   localparam int         PHASE_ITEMS  = 120;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         LIMIT_TIME   = 1000000;
   localparam logic [1:0] CSR_UNUSED   = 2'd3;

   typedef logic [7:0] octet_list [$];

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;
   bit         no_idle = 1'b0;

   packet_verdict_board sb;

   motor_link_response_classifier_core #(
      .MAX_PACKET(MAX_PACKET)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Idle lengths: mostly none or short, now and then long.
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // Settings lean toward the extremes.
   function automatic logic [7:0] pick_setting();
      int roll;
      roll = $urandom_range(0, 3);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   // Overwrite one byte so that the whole packet sums to zero.
   function automatic octet_list sealed(octet_list pkt, int pos);
      logic [7:0] total;
      total = 8'h00;
      foreach (pkt[i]) if (i != pos) total = total + pkt[i];
      pkt[pos] = 8'h00 - total;
      return pkt;
   endfunction

   // Long packet near or past the saturation point of the count.
   function automatic octet_list long_packet(int size);
      octet_list pkt;
      pkt.push_back(sb.cfg.sent_address);
      for (int i = 1; i < size; i++) pkt.push_back(8'($urandom));
      return sealed(pkt, 1);
   endfunction

   // Mostly well-formed responses with random content, plus noise and damage.
   function automatic octet_list random_packet();
      octet_list  pkt;
      int         kind;
      int         size;
      int         pos;
      logic [7:0] code;
      logic [7:0] data_len;
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         pkt = '{sb.cfg.sent_address, ACK_MARK, 8'h00};
         pkt = sealed(pkt, 2);
      end else if (kind < 32) begin
         size = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 10) : $urandom_range(6, 7);
         code = (size == 7 && $urandom_range(0, 1) == 1) ? NAK_SHORT :
                8'($urandom_range(NAK_MIN, NAK_MAX));
         if ($urandom_range(0, 7) == 0) code = 8'($urandom_range(0, 15));
         pkt = '{sb.cfg.sent_address, 8'h00, NAK_MARK, code, sb.cfg.sent_command};
         for (int i = 5; i < size; i++) pkt.push_back(8'($urandom));
         pkt = sealed(pkt, 1);
      end else if (kind < 58) begin
         data_len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 20)) :
                    8'($urandom_range(0, 6));
         pkt = '{sb.cfg.sent_address, data_len, sb.cfg.sent_command};
         for (int i = 0; i < data_len; i++) pkt.push_back(8'($urandom));
         if (data_len != 8'h00) pkt = sealed(pkt, pkt.size() - 1);
      end else if (kind < 72) begin
         size = $urandom_range(5, 8);
         pkt = '{sb.cfg.sent_address, POLL_LEN, POLL_CMD};
         for (int i = 3; i < size; i++) pkt.push_back(8'($urandom));
         pkt = sealed(pkt, size - 1);
      end else begin
         size = $urandom_range(1, 12);
         for (int i = 0; i < size; i++) pkt.push_back(8'($urandom));
         if ($urandom_range(0, 1) == 1) pkt[0] = sb.cfg.sent_address;
         if ($urandom_range(0, 1) == 1) pkt = sealed(pkt, (size > 1) ? size - 1 : 0);
      end
      // Damage a fraction of the packets by flipping bits in one byte.
      if ($urandom_range(0, 99) < 15) begin
         pos = $urandom_range(0, pkt.size() - 1);
         pkt[pos] = pkt[pos] ^ 8'($urandom_range(1, 255));
      end
      return pkt;
   endfunction

   // Offer one byte and hold it until accepted; idle afterward at random.
   task automatic push_byte(input req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(item);
      gap = no_idle ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_packet(input octet_list pkt);
      req_type item;
      foreach (pkt[i]) begin
         item.rx_byte = pkt[i];
         item.last_byte = (i == pkt.size() - 1);
         push_byte(item);
      end
   endtask

   // Valid stays high across back-to-back writes; the caller lowers it.
   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(index, value);
   endtask

   task automatic load_settings(input logic [7:0] address, input logic [7:0] length,
                                input logic [7:0] command, input bit touch_unused);
      write_reg(CSR_SENT_ADDRESS, address);
      write_reg(CSR_SENT_LENGTH, length);
      write_reg(CSR_SENT_COMMAND, command);
      if (touch_unused) write_reg(CSR_UNUSED, 8'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Hold off until every verdict is in and the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result stalls, independent of the sender.
   initial begin
      int idle;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         idle = no_idle ? 0 : idle_len();
         if (idle > 0) begin
            rsp_ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Results are checked at the edge where they are accepted.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_verdict(rsp_data);
   end

   initial begin
      #(LIMIT_TIME);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      octet_list pkt;
      int        sent_bytes;
      int        phase_end;
      int        phase;
      sb = new(MAX_PACKET);
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_SENT_ADDRESS;
      csr_wdata <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed packets: acknowledge, top NAK code, one-byte data, full poll word,
      // a lone byte, and a bad checksum.
      load_settings(8'h5A, 8'h01, 8'h33, 1'b0);
      send_packet(sealed('{8'h5A, ACK_MARK, 8'h00}, 2));
      send_packet(sealed('{8'h5A, 8'h00, NAK_MARK, NAK_MAX, 8'h33, 8'h00}, 5));
      send_packet(sealed('{8'h5A, 8'h01, 8'h33, 8'h00}, 3));
      send_packet(sealed('{8'h5A, POLL_LEN, POLL_CMD, 8'hFF, 8'hFF, 8'h00}, 5));
      send_packet('{8'h00});
      send_packet('{8'h5A, ACK_MARK, 8'h00});
      // Zero-length data packet whose address and command alone sum to zero.
      settle();
      load_settings(8'h10, 8'h00, 8'hF0, 1'b1);
      send_packet('{8'h10, 8'h00, 8'hF0});

      // Random phases, each under fresh settings and entered with nothing pending.
      sent_bytes = 0;
      phase = 0;
      while (sent_bytes < RANDOM_ITEMS) begin
         settle();
         load_settings(pick_setting(), pick_setting(), pick_setting(), $urandom_range(0, 1));
         if (phase == 2 || phase == 5) begin
            pkt = long_packet((phase == 2) ? MAX_PACKET - 1 : $urandom_range(MAX_PACKET,
                                                                             MAX_PACKET + 6));
            send_packet(pkt);
            sent_bytes += pkt.size();
         end
         // The last phase stops at the overall byte budget.
         phase_end = sent_bytes + PHASE_ITEMS;
         if (phase_end > RANDOM_ITEMS) phase_end = RANDOM_ITEMS;
         while (sent_bytes < phase_end) begin
            pkt = random_packet();
            no_idle = ($urandom_range(0, 7) == 0);
            send_packet(pkt);
            sent_bytes += pkt.size();
         end
         no_idle = 1'b0;
         phase++;
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mlrc_pkg.sv
rtl/mlrc_classify.sv
rtl/motor_link_response_classifier_core.sv
tb/sv/tb_motor_link_response_classifier_core.sv
